// ===== sv/cpni_pkg.sv =====
// Shared types, constants and helpers for the circle pair nearest intersection pipeline.
package cpni_pkg;

	localparam int WORD_W        = 32;
	localparam int RADIUS_W      = 31;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SQ_STEPS      = 32;
	localparam int DIV_STEPS     = 32;

	typedef struct packed {
		logic signed [WORD_W-1:0] first_x;
		logic signed [WORD_W-1:0] first_y;
		logic signed [WORD_W-1:0] second_x;
		logic signed [WORD_W-1:0] second_y;
	} op_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] point_x;
		logic signed [WORD_W-1:0] point_y;
		logic                     no_intersection;
	} res_t;

	// side data riding alongside the square root pipeline
	typedef struct packed {
		logic                     fail;
		logic signed [WORD_W-1:0] sx;
		logic signed [WORD_W-1:0] sy;
		logic [WORD_W-1:0]        adx;
		logic [WORD_W-1:0]        ady;
		logic                     negx;
		logic                     negy;
	} sq_side_t;

	// side data riding alongside the divider pipeline
	typedef struct packed {
		logic                     fail;
		logic signed [WORD_W-1:0] sx;
		logic signed [WORD_W-1:0] sy;
		logic                     negx;
		logic                     negy;
	} dv_side_t;

	// magnitude of a 33-bit two's complement value
	function automatic logic [WORD_W-1:0] mag33(input logic [WORD_W:0] v);
		return v[WORD_W] ? WORD_W'(-v) : v[WORD_W-1:0];
	endfunction

	// magnitude of a 32-bit two's complement value (most negative fits unsigned)
	function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? WORD_W'(-v) : v;
	endfunction

	// clamp a 34-bit signed value to the 32-bit range
	function automatic logic [WORD_W-1:0] sat34(input logic signed [WORD_W+1:0] v);
		logic signed [WORD_W+1:0] hi;
		logic signed [WORD_W+1:0] lo;
		hi = (WORD_W+2)'(34'sh0_7FFF_FFFF);
		lo = -(WORD_W+2)'(34'sh0_8000_0000);
		if (v > hi)
			return {1'b0, {(WORD_W-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(WORD_W-1){1'b0}}};
		else
			return v[WORD_W-1:0];
	endfunction

endpackage

// ===== sv/cpni_sqrt.sv =====
// Two-lane pipelined integer square root, one result bit per stage.
module cpni_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [63:0]        in_a,
	input  logic [63:0]        in_b,
	input  cpni_pkg::sq_side_t in_side,
	output logic               out_valid,
	output logic [31:0]        root_a,
	output logic [31:0]        root_b,
	output cpni_pkg::sq_side_t out_side
);
	import cpni_pkg::*;

	logic [63:0] n_s    [0:SQ_STEPS][0:1];
	logic [33:0] rem_s  [0:SQ_STEPS][0:1];
	logic [31:0] root_s [0:SQ_STEPS][0:1];
	logic        v_s    [0:SQ_STEPS];
	sq_side_t    side_s [0:SQ_STEPS];

	logic [35:0] cur_c   [0:SQ_STEPS-1][0:1];
	logic [35:0] trial_c [0:SQ_STEPS-1][0:1];
	logic        fit_c   [0:SQ_STEPS-1][0:1];

	// digit recurrence: bring down two bits, try (root<<2)|1
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				cur_c[k][l]   = {rem_s[k][l], n_s[k][l][63:62]};
				trial_c[k][l] = {2'b00, root_s[k][l], 2'b01};
				fit_c[k][l]   = cur_c[k][l] >= trial_c[k][l];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQ_STEPS; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < SQ_STEPS; k++) v_s[k+1] <= v_s[k];
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		n_s[0][0]    <= in_a;
		n_s[0][1]    <= in_b;
		side_s[0]    <= in_side;
		for (int l = 0; l < 2; l++) begin
			rem_s[0][l]  <= '0;
			root_s[0][l] <= '0;
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			side_s[k+1] <= side_s[k];
			for (int l = 0; l < 2; l++) begin
				n_s[k+1][l]    <= {n_s[k][l][61:0], 2'b00};
				rem_s[k+1][l]  <= fit_c[k][l] ? 34'(cur_c[k][l] - trial_c[k][l])
				                              : cur_c[k][l][33:0];
				root_s[k+1][l] <= {root_s[k][l][30:0], fit_c[k][l]};
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign root_a    = root_s[SQ_STEPS][0];
	assign root_b    = root_s[SQ_STEPS][1];
	assign out_side  = side_s[SQ_STEPS];

endmodule

// ===== sv/cpni_div.sv =====
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module cpni_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [63:0]        num_a,
	input  logic [63:0]        num_b,
	input  logic [32:0]        divisor,
	input  cpni_pkg::dv_side_t in_side,
	output logic               out_valid,
	output logic [31:0]        quot_a,
	output logic [31:0]        quot_b,
	output cpni_pkg::dv_side_t out_side
);
	import cpni_pkg::*;

	// quotient is known to fit 32 bits, so the upper word starts as remainder
	logic [32:0] rem_s  [0:DIV_STEPS][0:1];
	logic [31:0] low_s  [0:DIV_STEPS][0:1];
	logic [31:0] q_s    [0:DIV_STEPS][0:1];
	logic [32:0] dv_s   [0:DIV_STEPS];
	logic        v_s    [0:DIV_STEPS];
	dv_side_t    side_s [0:DIV_STEPS];

	logic [33:0] cur_c [0:DIV_STEPS-1][0:1];
	logic        fit_c [0:DIV_STEPS-1][0:1];

	// shift in one bit and trial subtract
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				cur_c[k][l] = {rem_s[k][l], low_s[k][l][31]};
				fit_c[k][l] = cur_c[k][l] >= {1'b0, dv_s[k]};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < DIV_STEPS; k++) v_s[k+1] <= v_s[k];
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		rem_s[0][0] <= {1'b0, num_a[63:32]};
		low_s[0][0] <= num_a[31:0];
		rem_s[0][1] <= {1'b0, num_b[63:32]};
		low_s[0][1] <= num_b[31:0];
		q_s[0][0]   <= '0;
		q_s[0][1]   <= '0;
		dv_s[0]     <= divisor;
		side_s[0]   <= in_side;
		for (int k = 0; k < DIV_STEPS; k++) begin
			dv_s[k+1]   <= dv_s[k];
			side_s[k+1] <= side_s[k];
			for (int l = 0; l < 2; l++) begin
				rem_s[k+1][l] <= fit_c[k][l] ? 33'(cur_c[k][l] - {1'b0, dv_s[k]})
				                             : cur_c[k][l][32:0];
				low_s[k+1][l] <= {low_s[k][l][30:0], 1'b0};
				q_s[k+1][l]   <= {q_s[k][l][30:0], fit_c[k][l]};
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign quot_a    = q_s[DIV_STEPS][0];
	assign quot_b    = q_s[DIV_STEPS][1];
	assign out_side  = side_s[DIV_STEPS];

endmodule

// ===== sv/circle_pair_nearest_intersection.sv =====
// Top level: nearest intersection point of two equal-radius circles, fully pipelined.
//
// Usage. A transaction enters on operands when start is high and busy is low; busy
// is held low, so a new pair of centres may be issued on every clock cycle.
// Each transaction yields exactly one result on result, shown for one cycle with
// done high, in issue order. The pipeline holds the two 33-stage bit-serial
// units (square root and divider, one bit per stage) plus seven stages of
// multiply, add and select.
// Throughput is one transaction per cycle.
// cfg_we writes cfg_data into the circle radius (unsigned Q15.16); the value is
// sampled when a transaction enters, so write it only with the pipeline empty.
// Reset (arst_n low) clears every valid bit and sets the radius to 1.0; any
// transactions in flight are dropped. The receiver cannot stall: each result
// must be taken in its one cycle.
// no_intersection is set, with a zero point, when the circles are apart or the
// centres coincide.
module circle_pair_nearest_intersection #(
	parameter int FRAC_BITS = cpni_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  cpni_pkg::op_t                   operands,
	output logic                            done,
	output cpni_pkg::res_t                  result,
	input  logic                            cfg_we,
	input  logic [cpni_pkg::RADIUS_W-1:0]   cfg_data
);
	import cpni_pkg::*;

	localparam int LATENCY = 3 + (SQ_STEPS + 1) + 1 + (DIV_STEPS + 1) + 3;

	logic [RADIUS_W-1:0] radius_q;

	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] sx_s1, sy_s1;
	logic [31:0]        tr_s1;
	logic               v_s1;

	logic [63:0] dx2_s2, dy2_s2, lim_s2;
	sq_side_t    side_s2;
	logic        v_s2;

	logic [64:0] d2_s3;
	logic [63:0] lim_s3;
	sq_side_t    side_s3;
	logic        v_s3;

	sq_side_t    sq_in_side, sq_out_side;
	logic        sq_valid;
	logic [31:0] sq_root, sd_root;

	logic [63:0] prodx_s37, prody_s37;
	logic [31:0] sd_s37;
	dv_side_t    side_s37;
	logic        v_s37;

	dv_side_t    dv_out_side;
	logic        dv_valid;
	logic [31:0] qx, qy;

	logic signed [33:0] ox_c, oy_c, sx_c, sy_c;

	logic [31:0] p1x_s71, p1y_s71, p2x_s71, p2y_s71;
	logic        fail_s71, v_s71;

	logic [63:0] m1x_s72, m1y_s72, m2x_s72, m2y_s72;
	logic [31:0] p1x_s72, p1y_s72, p2x_s72, p2y_s72;
	logic        fail_s72, v_s72;

	res_t        res_q;
	logic        done_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			radius_q <= cfg_data;
		end
	end

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	// valid chain outside the iterative units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s37  <= 1'b0;
			v_s71  <= 1'b0;
			v_s72  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s37  <= sq_valid;
			v_s71  <= dv_valid;
			v_s72  <= v_s71;
			done_q <= v_s72;
		end
	end

	// stage 1: differences, midpoint, diameter
	always_ff @(posedge clk) begin
		dx_s1 <= {operands.first_x[31], operands.first_x}
		       - {operands.second_x[31], operands.second_x};
		dy_s1 <= {operands.first_y[31], operands.first_y}
		       - {operands.second_y[31], operands.second_y};
		sx_s1 <= 32'(({operands.first_x[31], operands.first_x}
		       + {operands.second_x[31], operands.second_x}) >>> 1);
		sy_s1 <= 32'(({operands.first_y[31], operands.first_y}
		       + {operands.second_y[31], operands.second_y}) >>> 1);
		tr_s1 <= {radius_q, 1'b0};
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		dx2_s2       <= 64'(mag33(dx_s1)) * 64'(mag33(dx_s1));
		dy2_s2       <= 64'(mag33(dy_s1)) * 64'(mag33(dy_s1));
		lim_s2       <= 64'(tr_s1) * 64'(tr_s1);
		side_s2.fail <= 1'b0;
		side_s2.sx   <= sx_s1;
		side_s2.sy   <= sy_s1;
		side_s2.adx  <= mag33(dx_s1);
		side_s2.ady  <= mag33(dy_s1);
		side_s2.negx <= dx_s1[32];
		side_s2.negy <= dy_s1[32];
	end

	// stage 3: squared centre distance, kept exact
	always_ff @(posedge clk) begin
		d2_s3   <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
		lim_s3  <= lim_s2;
		side_s3 <= side_s2;
	end

	// apart or coincident test feeds the root unit's first stage
	always_comb begin
		sq_in_side      = side_s3;
		sq_in_side.fail = (d2_s3 == '0) || (d2_s3 > {1'b0, lim_s3});
	end

	cpni_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_a     (64'(lim_s3 - d2_s3[63:0])),
		.in_b     (d2_s3[63:0]),
		.in_side  (sq_in_side),
		.out_valid(sq_valid),
		.root_a   (sq_root),
		.root_b   (sd_root),
		.out_side (sq_out_side)
	);

	// offset numerators
	always_ff @(posedge clk) begin
		prodx_s37     <= 64'(sq_out_side.ady) * 64'(sq_root);
		prody_s37     <= 64'(sq_out_side.adx) * 64'(sq_root);
		sd_s37        <= sd_root;
		side_s37.fail <= sq_out_side.fail;
		side_s37.sx   <= sq_out_side.sx;
		side_s37.sy   <= sq_out_side.sy;
		side_s37.negx <= sq_out_side.negx;
		side_s37.negy <= sq_out_side.negy;
	end

	// rounded division by 2*sd
	cpni_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s37),
		.num_a    (64'(prodx_s37 + 64'(sd_s37))),
		.num_b    (64'(prody_s37 + 64'(sd_s37))),
		.divisor  ({sd_s37, 1'b0}),
		.in_side  (side_s37),
		.out_valid(dv_valid),
		.quot_a   (qx),
		.quot_b   (qy),
		.out_side (dv_out_side)
	);

	// signed offsets and the two candidate points
	always_comb begin
		ox_c = dv_out_side.negy ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
		oy_c = dv_out_side.negx ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
		sx_c = 34'(dv_out_side.sx);
		sy_c = 34'(dv_out_side.sy);
	end

	always_ff @(posedge clk) begin
		p1x_s71  <= sat34(sx_c - ox_c);
		p1y_s71  <= sat34(sy_c + oy_c);
		p2x_s71  <= sat34(sx_c + ox_c);
		p2y_s71  <= sat34(sy_c - oy_c);
		fail_s71 <= dv_out_side.fail;
	end

	// distance to origin, squared
	always_ff @(posedge clk) begin
		m1x_s72  <= 64'(mag32(p1x_s71)) * 64'(mag32(p1x_s71));
		m1y_s72  <= 64'(mag32(p1y_s71)) * 64'(mag32(p1y_s71));
		m2x_s72  <= 64'(mag32(p2x_s71)) * 64'(mag32(p2x_s71));
		m2y_s72  <= 64'(mag32(p2y_s71)) * 64'(mag32(p2y_s71));
		p1x_s72  <= p1x_s71;
		p1y_s72  <= p1y_s71;
		p2x_s72  <= p2x_s71;
		p2y_s72  <= p2y_s71;
		fail_s72 <= fail_s71;
	end

	// pick the nearer point; a tie keeps the first
	always_ff @(posedge clk) begin
		if (fail_s72) begin
			res_q.point_x <= '0;
			res_q.point_y <= '0;
		end else if ((m1x_s72 + m1y_s72) > (m2x_s72 + m2y_s72)) begin
			res_q.point_x <= p2x_s72;
			res_q.point_y <= p2y_s72;
		end else begin
			res_q.point_x <= p1x_s72;
			res_q.point_y <= p1y_s72;
		end
		res_q.no_intersection <= fail_s72;
	end

	assign done   = done_q;
	assign result = res_q;

	// every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe out of step with issue");

	// a flagged result carries a zero point
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.no_intersection) |-> (result.point_x == '0 && result.point_y == '0))
		else $error("flagged result with non-zero point");

	// coincident centres must come out flagged
	a_coincident: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && d2_s3 == '0) |-> ##(LATENCY-3) (done && result.no_intersection))
		else $error("coincident centres not flagged");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the circle pair nearest intersection pipeline.
module tb_top;
	import cpni_pkg::*;

	localparam int  PIPE_LAT    = 73;
	localparam int  SETTLE      = PIPE_LAT + 10;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  PHASE_ITEMS = 167;
	localparam logic [RADIUS_W-1:0] RADIUS_ONE = 31'd65536;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX = 31'h7FFF_FFFF;
	localparam logic signed [31:0]  S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]  S_MIN = 32'sh8000_0000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	op_t                 operands;
	logic                done;
	res_t                result;
	logic                cfg_we;
	logic [RADIUS_W-1:0] cfg_data;

	op_t                 pending_q[$];
	res_t                nearest_q[$];
	logic [RADIUS_W-1:0] radius_now;
	logic                taken;
	logic                burst;
	int                  gap;
	int                  errors;
	int                  cycles;

	circle_pair_nearest_intersection u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// integer square root, floor
	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic signed [127:0] widen(input logic signed [31:0] v);
		return {{96{v[31]}}, v};
	endfunction

	function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
		if (v > widen(S_MAX))
			return widen(S_MAX);
		if (v < widen(S_MIN))
			return widen(S_MIN);
		return v;
	endfunction

	// expected nearest intersection for one centre pair at the given radius
	function automatic res_t nearest_point(input op_t op, input logic [RADIUS_W-1:0] r);
		logic signed [127:0] dx, dy, adx, ady, d2, lim, two_r;
		logic signed [127:0] sx, sy, ox, oy, p1x, p1y, p2x, p2y, m1, m2;
		logic [63:0]         sq, sd;
		res_t                res;
		res = '0;
		dx = widen(op.first_x) - widen(op.second_x);
		dy = widen(op.first_y) - widen(op.second_y);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		d2 = adx * adx + ady * ady;
		two_r = 128'(r) * 2;
		lim = two_r * two_r;
		if (d2 == 0 || d2 >= (128'sd1 <<< 64) || d2 > lim) begin
			res.no_intersection = 1'b1;
			return res;
		end
		sq = int_sqrt(64'(lim - d2));
		sd = int_sqrt(64'(d2));
		ox = (ady * 128'(sq) + 128'(sd)) / (128'(sd) * 2);
		oy = (adx * 128'(sq) + 128'(sd)) / (128'(sd) * 2);
		if (dy < 0)
			ox = -ox;
		if (dx < 0)
			oy = -oy;
		sx = (widen(op.first_x) + widen(op.second_x)) >>> 1;
		sy = (widen(op.first_y) + widen(op.second_y)) >>> 1;
		p1x = clamp32(sx - ox);
		p1y = clamp32(sy + oy);
		p2x = clamp32(sx + ox);
		p2y = clamp32(sy - oy);
		m1 = p1x * p1x + p1y * p1y;
		m2 = p2x * p2x + p2y * p2y;
		// tie keeps the first point
		if (m1 > m2) begin
			res.point_x = p2x[31:0];
			res.point_y = p2y[31:0];
		end else begin
			res.point_x = p1x[31:0];
			res.point_y = p1y[31:0];
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// acceptance and result check
	always @(posedge clk) begin
		res_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			if (start && !busy) begin
				nearest_q.push_back(nearest_point(operands, radius_now));
				taken = 1'b1;
			end
			if (done) begin
				if (nearest_q.size() == 0) begin
					report("unexpected transaction", result.point_x, '0);
				end else begin
					want = nearest_q.pop_front();
					if (result.point_x !== want.point_x)
						report("point_x", result.point_x, want.point_x);
					if (result.point_y !== want.point_y)
						report("point_y", result.point_y, want.point_y);
					if (result.no_intersection !== want.no_intersection)
						report("no_intersection", 32'(result.no_intersection),
							32'(want.no_intersection));
				end
			end
		end
	end

	// driver: one transaction per pending item, random gap after each unless in a burst
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			taken = 1'b0;
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending_q.size() != 0) begin
				operands <= pending_q.pop_front();
				start <= 1'b1;
				gap = burst ? 0 : $urandom_range(0, 7);
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic add_pair(input logic [31:0] x1, input logic [31:0] y1,
			input logic [31:0] x2, input logic [31:0] y2);
		op_t op;
		op.first_x = x1;
		op.first_y = y1;
		op.second_x = x2;
		op.second_y = y2;
		pending_q.push_back(op);
	endtask

	// coordinate near a centre, stepping inward so it stays in range
	function automatic logic [31:0] near_coord(input logic signed [31:0] c,
			input logic [RADIUS_W-1:0] r);
		logic signed [32:0] step;
		step = 33'($urandom_range(0, r));
		return c >= 0 ? 32'(c - step) : 32'(c + step);
	endfunction

	function automatic logic [31:0] pick_coord();
		if ($urandom_range(0, 1))
			return $urandom;
		return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
	endfunction

	task automatic add_random(input int count, input logic [RADIUS_W-1:0] r);
		logic [31:0] ax, ay;
		int          kind;
		repeat (count) begin
			ax = pick_coord();
			ay = pick_coord();
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				add_pair($urandom, $urandom, $urandom, $urandom);
			end else if (kind == 3 && r < 31'h2000_0000) begin
				// touching circles along x
				ax = 32'($urandom_range(0, 32'h3FFF_FFFF)) - 32'h2000_0000;
				add_pair(ax, ay, ax + 32'(r) * 2, ay);
			end else begin
				add_pair(ax, ay, near_coord(ax, r), near_coord(ay, r));
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || nearest_q.size() != 0 || start)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_radius(input logic [RADIUS_W-1:0] r);
		wait_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = r;
		radius_now = r;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// stimulus
	initial begin
		logic [RADIUS_W-1:0] radii[7];
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		radius_now = RADIUS_ONE;
		taken = 1'b0;
		burst = 1'b0;
		gap = 0;
		errors = 0;
		cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed at the reset radius of 1.0
		add_pair(0, 0, 0, 0);                       // coincident centres
		add_pair(0, 0, 32'd131072, 0);              // touching
		add_pair(0, 0, 32'd200000, 0);              // apart
		add_pair(0, 0, 32'd65536, 0);
		add_pair(32'd65536, 32'd65536, 0, 0);
		add_pair(-32'd65536, 0, 32'd65536, 0);      // equidistant points, tie
		add_pair(32'd10000, -32'd40000, -32'd30000, 32'd20000);
		add_pair(S_MIN, S_MIN, S_MAX, S_MAX);
		add_pair(S_MAX, S_MAX, S_MAX - 1000, S_MAX);
		add_pair(S_MIN, S_MIN, S_MIN + 1000, S_MIN);
		add_pair(S_MAX, S_MIN, S_MAX, S_MIN + 70000);
		add_random(PHASE_ITEMS, radius_now);

		// extreme radius, saturated points included
		set_radius(RADIUS_MAX);
		add_pair(S_MIN, 0, S_MAX, 0);               // just apart
		add_pair(S_MIN, S_MIN, S_MAX - 1, S_MIN);   // touching at full span
		add_pair(S_MAX, S_MAX, S_MAX - 1, S_MAX);
		add_pair(S_MIN, S_MIN, S_MIN, S_MIN + 1);
		add_pair(0, 0, 1, 0);
		add_random(PHASE_ITEMS, radius_now);

		// zero radius: distinct centres never meet
		set_radius('0);
		add_pair(5, 5, 6, 5);
		add_pair(5, 5, 5, 5);
		add_random(60, radius_now);

		// pause until all results are in, then a back-to-back stretch
		wait_idle();
		burst = 1'b1;
		add_random(PHASE_ITEMS, radius_now);
		wait_idle();
		burst = 1'b0;

		radii[0] = 31'd1;
		radii[1] = 31'd3;
		radii[2] = 31'($urandom_range(0, 32'h000F_FFFF));
		radii[3] = 31'($urandom);
		radii[4] = 31'($urandom_range(32'h7000_0000, 32'h7FFF_FFFF));
		radii[5] = RADIUS_MAX;
		radii[6] = RADIUS_ONE;
		foreach (radii[i]) begin
			set_radius(radii[i]);
			burst = (i % 3 == 2);
			add_random(PHASE_ITEMS, radius_now);
		end

		wait_idle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
